/* rtl/ape_cover_item_selector_assert.svh */
// Assertion macros for the APE cover item selector
`ifndef APE_COVER_ITEM_SELECTOR_ASSERT_SVH
`define APE_COVER_ITEM_SELECTOR_ASSERT_SVH
// Check that a condition implies a consequence in the same cycle
`define ACIS_ASSERT_IMPL(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
		else $error("assertion failed");
// Check that a condition implies a consequence in the next cycle
`define ACIS_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error("assertion failed");
`endif

/* rtl/acis_pkg.sv */
// Package for the APE cover item selector: payload types and constants
`timescale 1ns / 1ps
package acis_pkg;
	localparam int unsigned MAX_TAG_BYTES_DEF = 16777216;
	localparam int unsigned KEY_LETTER_LIMIT_DEF = 63;
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned HEADER_BYTES = 32;
	localparam logic [63:0] LEAD_MAGIC = 64'h5845474154455041;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic        found;
		logic [23:0] image_offset;
		logic [23:0] image_length;
		logic [1:0]  image_rank;
	} out_item_t;

	// Classified byte handed from front to back
	typedef struct packed {
		logic [7:0]  data_byte;
		logic        last_byte;
		logic        in_range;
		logic [23:0] position;
		logic        is_letter;
		logic [4:0]  letter_code;
	} cls_item_t;
endpackage

/* rtl/acis_front.sv */
// Front end: accepts bytes, tracks position, classifies letters
`timescale 1ns / 1ps
module acis_front #(
	parameter int unsigned MAX_TAG_BYTES = acis_pkg::MAX_TAG_BYTES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  acis_pkg::in_item_t   in_data,
	output logic                 cls_valid,
	input  logic                 cls_ready,
	output acis_pkg::cls_item_t  cls_data
);
	localparam int unsigned PW = $clog2(MAX_TAG_BYTES + 1);
	logic [PW-1:0] pos_q;
	logic [7:0] low_b;
	logic acc;

	assign in_ready = cls_ready;
	assign cls_valid = in_valid;
	assign acc = in_valid && cls_ready;
	// Fold upper case to lower case
	assign low_b = (in_data.data_byte inside {[8'h41:8'h5A]}) ?
		in_data.data_byte + 8'd32 : in_data.data_byte;

	always_comb begin
		cls_data.data_byte = in_data.data_byte;
		cls_data.last_byte = in_data.last_byte;
		cls_data.in_range = (64'(pos_q) < 64'(MAX_TAG_BYTES));
		cls_data.position = 24'(pos_q);
		cls_data.is_letter = (low_b inside {[8'h61:8'h7A]});
		cls_data.letter_code = 5'(low_b - 8'h60);
	end

	// Advance position; restart after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (acc) begin
			if (in_data.last_byte) pos_q <= '0;
			else if (64'(pos_q) < 64'(MAX_TAG_BYTES)) pos_q <= pos_q + 1'b1;
		end
	end
endmodule

/* rtl/acis_queue.sv */
// Short FIFO between front and back
`timescale 1ns / 1ps
module acis_queue #(
	parameter int unsigned DEPTH = acis_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_valid,
	output logic                wr_ready,
	input  acis_pkg::cls_item_t wr_data,
	output logic                rd_valid,
	input  logic                rd_ready,
	output acis_pkg::cls_item_t rd_data
);
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	acis_pkg::cls_item_t mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;
	logic wr, rd;

	assign wr_ready = (cnt_q != (AW+1)'(DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_data = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	// Store entries
	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (rd) rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
		end
	end
endmodule

/* rtl/acis_back.sv */
// Back end: item parser, key matching, best image and result register
`timescale 1ns / 1ps
module acis_back #(
	parameter int unsigned KEY_LETTER_LIMIT = acis_pkg::KEY_LETTER_LIMIT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cls_valid,
	output logic                cls_ready,
	input  acis_pkg::cls_item_t cls_data,
	output logic                out_valid,
	input  logic                out_ready,
	output acis_pkg::out_item_t out_data
);
	localparam int unsigned LW = $clog2(KEY_LETTER_LIMIT + 1);
	typedef enum logic [2:0] {PH_LEAD, PH_SKIP, PH_HEAD, PH_KEY, PH_VALUE} phase_t;

	phase_t phase_q;
	logic [63:0] lead_q;
	logic [31:0] fcnt_q, vrem_q, nlen_q;
	logic [LW-1:0] lcnt_q;
	logic [34:0] win_q;
	logic [3:0] hits_q;
	logic nend_q;
	logic [23:0] vstart_q;
	logic bvalid_q;
	logic [23:0] boff_q, blen_q;
	logic [1:0] brank_q;
	logic ovalid_q;
	acis_pkg::out_item_t odata_q;
	logic acc;

	assign cls_ready = !ovalid_q || out_ready;
	assign acc = cls_valid && cls_ready;
	assign out_valid = ovalid_q;
	assign out_data = odata_q;

	// Next-state signals of the best-image tracker and parser
	logic [34:0] win_n;
	logic [3:0] hits_n;
	logic fin;
	logic [1:0] rank_c;
	logic [31:0] len_c;
	logic [23:0] off_c;
	logic take;
	logic [63:0] lead_n;
	logic [31:0] vrem_dec;

	always_comb begin
		win_n = {win_q[29:0], cls_data.letter_code};
		hits_n = hits_q;
		if (win_n[24:0] == {5'd3, 5'd15, 5'd22, 5'd5, 5'd18}) hits_n[0] = 1'b1;
		if (win_n == {5'd16, 5'd9, 5'd3, 5'd20, 5'd21, 5'd18, 5'd5}) hits_n[1] = 1'b1;
		if (win_n[24:0] == {5'd6, 5'd18, 5'd15, 5'd14, 5'd20}) hits_n[2] = 1'b1;
		if (win_n[19:0] == {5'd2, 5'd1, 5'd3, 5'd11}) hits_n[3] = 1'b1;
		lead_n = lead_q | (64'(cls_data.data_byte) << {cls_data.position[2:0], 3'b000});
		vrem_dec = vrem_q - 32'd1;
		fin = 1'b0;
		if (phase_q == PH_KEY && cls_data.data_byte == 8'h00 && vrem_q == '0) fin = 1'b1;
		if (phase_q == PH_VALUE && vrem_dec == '0) fin = 1'b1;
		rank_c = hits_q[2] ? 2'd0 : (hits_q[3] ? 2'd2 : 2'd1);
		// In the value phase the final byte's own count is folded in
		if (phase_q == PH_KEY) begin
			len_c = '0;
			off_c = cls_data.position + 24'd1;
		end else if (nend_q) begin
			len_c = fcnt_q + 32'd1;
			off_c = vstart_q + nlen_q[23:0] + 24'd1;
		end else begin
			// A zero as the final value byte leaves an empty image
			len_c = (cls_data.data_byte != 8'h00) ? nlen_q + 32'd1 : fcnt_q;
			off_c = vstart_q;
		end
		take = fin && cls_data.in_range && (hits_q[1:0] != 2'b00) && (len_c != '0) &&
			(!bvalid_q || rank_c < brank_q ||
			 (rank_c == brank_q && len_c[23:0] > blen_q));
	end

	// Hold parse state, best image and the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEAD;
			lead_q <= '0; fcnt_q <= '0; vrem_q <= '0; nlen_q <= '0;
			lcnt_q <= '0; win_q <= '0; hits_q <= '0; nend_q <= 1'b0;
			vstart_q <= '0; bvalid_q <= 1'b0; boff_q <= '0; blen_q <= '0;
			brank_q <= '0; ovalid_q <= 1'b0; odata_q <= '0;
		end else begin
			if (ovalid_q && out_ready) ovalid_q <= 1'b0;
			if (acc) begin
				if (cls_data.in_range) begin
					case (phase_q)
						PH_LEAD: begin
							lead_q <= lead_n;
							if (cls_data.position[2:0] == 3'd7) begin
								if (lead_n == acis_pkg::LEAD_MAGIC) begin
									phase_q <= PH_SKIP;
								end else begin
									vrem_q <= lead_n[31:0];
									lcnt_q <= '0; win_q <= '0; hits_q <= '0;
									phase_q <= PH_KEY;
								end
							end
						end
						PH_SKIP: begin
							if (cls_data.position + 24'd1 >= 24'(acis_pkg::HEADER_BYTES)) begin
								fcnt_q <= '0; vrem_q <= '0; phase_q <= PH_HEAD;
							end
						end
						PH_HEAD: begin
							if (fcnt_q < 32'd4)
								vrem_q <= vrem_q | (32'(cls_data.data_byte) << {fcnt_q[1:0], 3'b000});
							fcnt_q <= fcnt_q + 32'd1;
							if (fcnt_q + 32'd1 >= 32'd8) begin
								lcnt_q <= '0; win_q <= '0; hits_q <= '0;
								phase_q <= PH_KEY;
							end
						end
						PH_KEY: begin
							if (cls_data.data_byte == 8'h00) begin
								vstart_q <= cls_data.position + 24'd1;
								nend_q <= 1'b0; nlen_q <= '0; fcnt_q <= '0;
								if (fin) begin
									vrem_q <= '0; phase_q <= PH_HEAD;
								end else begin
									phase_q <= PH_VALUE;
								end
							end else if (32'(lcnt_q) < 32'(KEY_LETTER_LIMIT) &&
								cls_data.is_letter) begin
								lcnt_q <= lcnt_q + 1'b1;
								win_q <= win_n;
								hits_q <= hits_n;
							end
						end
						PH_VALUE: begin
							if (nend_q) fcnt_q <= fcnt_q + 32'd1;
							else if (cls_data.data_byte == 8'h00) nend_q <= 1'b1;
							else nlen_q <= nlen_q + 32'd1;
							vrem_q <= vrem_dec;
							if (fin) begin
								fcnt_q <= '0; vrem_q <= '0; phase_q <= PH_HEAD;
							end
						end
						default: phase_q <= PH_LEAD;
					endcase
					if (take) begin
						bvalid_q <= 1'b1; boff_q <= off_c;
						blen_q <= len_c[23:0]; brank_q <= rank_c;
					end
				end
				// Report and restart on the final byte
				if (cls_data.last_byte) begin
					ovalid_q <= 1'b1;
					if (take) begin
						odata_q <= {1'b1, off_c, len_c[23:0], rank_c};
					end else if (bvalid_q) begin
						odata_q <= {1'b1, boff_q, blen_q, brank_q};
					end else begin
						odata_q <= '0;
					end
					phase_q <= PH_LEAD;
					lead_q <= '0; fcnt_q <= '0; vrem_q <= '0; nlen_q <= '0;
					lcnt_q <= '0; win_q <= '0; hits_q <= '0; nend_q <= 1'b0;
					vstart_q <= '0; bvalid_q <= 1'b0; boff_q <= '0; blen_q <= '0;
					brank_q <= '0;
				end
			end
		end
	end
endmodule

/* rtl/ape_cover_item_selector.sv */
// Top level of the APE cover item selector
//
// Channel | Direction | Payload
// in      | request   | data_byte, last_byte
// out     | result    | found, image_offset, image_length, image_rank
//
// One byte per cycle sustained while results are taken; the back-end parser updates once per byte.
// A result appears in the cycle after its final byte leaves the queue.
// Reset clears parse state, queue pointers and the result register.
// A stalled result stalls the parser; the queue then fills and backs up input.
`timescale 1ns / 1ps
`include "ape_cover_item_selector_assert.svh"
module ape_cover_item_selector #(
	parameter int unsigned MAX_TAG_BYTES = acis_pkg::MAX_TAG_BYTES_DEF,
	parameter int unsigned KEY_LETTER_LIMIT = acis_pkg::KEY_LETTER_LIMIT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  acis_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output acis_pkg::out_item_t out_data
);
	acis_pkg::cls_item_t f_data, q_data;
	logic f_valid, f_ready, q_valid, q_ready;

	acis_front #(.MAX_TAG_BYTES(MAX_TAG_BYTES)) u_front (
		.clk, .arst_n, .in_valid, .in_ready, .in_data,
		.cls_valid(f_valid), .cls_ready(f_ready), .cls_data(f_data)
	);
	acis_queue #(.DEPTH(acis_pkg::QUEUE_DEPTH)) u_queue (
		.clk, .arst_n, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
		.rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
	);
	acis_back #(.KEY_LETTER_LIMIT(KEY_LETTER_LIMIT)) u_back (
		.clk, .arst_n, .cls_valid(q_valid), .cls_ready(q_ready), .cls_data(q_data),
		.out_valid, .out_ready, .out_data
	);

	`ACIS_ASSERT_IMPL(a_nf_zero, clk, arst_n, out_valid && !out_data.found, out_data.image_length == 24'd0 && out_data.image_rank == 2'd0)
	`ACIS_ASSERT_IMPL(a_rank_ok, clk, arst_n, out_valid, out_data.image_rank != 2'd3)
	`ACIS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))
endmodule
